/* rtl/ukt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_pkg
// Shared constants, codes and controller/datapath interface types for the
// unsorted key table.
// ----------------------------------------------------------------------------
package ukt_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;

    // command codes
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_SEARCH = 3'd2;
    localparam logic [2:0] CMD_MIN    = 3'd3;
    localparam logic [2:0] CMD_MAX    = 3'd4;
    localparam logic [2:0] CMD_PRED   = 3'd5;
    localparam logic [2:0] CMD_SUCC   = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       ins_write;
        logic       rd_last;
        logic       rd_slot;
        logic       del_write;
        logic       ref_load;
        logic       scan_clear;
        logic       scan_issue;
        logic       stat_load;
        logic [1:0] stat_code;
        logic       result_load;
    } ukt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       empty;
        logic       slot_bad;
        logic       issue_done;
        logic       cmp_pending;
        logic       have;
        logic       out_busy;
    } ukt_stat_t;

endpackage
`default_nettype wire

/* rtl/ukt_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_datapath
// Key memory, fill count, scan pipeline, compare unit and output register.
// ----------------------------------------------------------------------------
module ukt_datapath
    import ukt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ukt_cmd_t                ctl,
    output ukt_stat_t                    stat,
    input  wire logic [2:0]              command,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic [ADDR_W-1:0]       slot,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   status,
    output logic [ADDR_W-1:0]            found_index,
    output logic signed [KEY_W-1:0]      found_value,
    output logic [CNT_W-1:0]             entry_count
);

    logic signed [KEY_W-1:0] mem [CAPACITY];

    logic [2:0]              op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [ADDR_W-1:0]       slot_reg;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        fill_m1;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    cmp_valid_reg;
    logic [ADDR_W-1:0]       cmp_idx_reg;
    logic signed [KEY_W-1:0] rd_data_reg;
    logic signed [KEY_W-1:0] ref_reg;
    logic signed [KEY_W-1:0] best_reg, best_next;
    logic                    have_reg, have_next;
    logic [ADDR_W-1:0]       fidx_reg, fidx_next;
    logic [1:0]              stat_reg;
    logic                    out_valid_reg;
    logic [1:0]              status_reg;
    logic [ADDR_W-1:0]       found_index_reg;
    logic signed [KEY_W-1:0] found_value_reg;
    logic [CNT_W-1:0]        entry_count_reg;

    logic [ADDR_W-1:0]       rd_addr;
    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic                    take;

    assign fill_m1 = fill_reg - CNT_W'(1);

    always_comb
    begin
        if (ctl.rd_last)
            rd_addr = fill_m1[ADDR_W-1:0];
        else if (ctl.rd_slot)
            rd_addr = slot_reg;
        else
            rd_addr = idx_reg[ADDR_W-1:0];
    end

    assign wr_en   = ctl.ins_write | ctl.del_write;
    assign wr_addr = ctl.ins_write ? fill_reg[ADDR_W-1:0] : slot_reg;
    assign wr_data = ctl.ins_write ? key_reg : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (ctl.ins_write)
            fill_next = fill_reg + CNT_W'(1);
        else if (ctl.del_write)
            fill_next = fill_m1;
    end

    assign idx_next = ctl.scan_clear ? '0 :
                      ctl.scan_issue ? idx_reg + CNT_W'(1) : idx_reg;

    // compare the word read in the previous cycle
    always_comb
    begin
        best_next = best_reg;
        have_next = have_reg;
        fidx_next = fidx_reg;
        take      = 1'b0;
        if (cmp_valid_reg)
        begin
            case (op_reg)
                CMD_SEARCH: take = !have_reg && (rd_data_reg == key_reg);
                CMD_MIN:    take = !have_reg || (rd_data_reg < best_reg);
                CMD_MAX:    take = !have_reg || (rd_data_reg > best_reg);
                CMD_PRED:   take = (rd_data_reg < ref_reg) &&
                                   (!have_reg || (rd_data_reg > best_reg));
                CMD_SUCC:   take = (rd_data_reg > ref_reg) &&
                                   (!have_reg || (rd_data_reg < best_reg));
                default:    take = 1'b0;
            endcase
        end
        if (take)
        begin
            best_next = rd_data_reg;
            have_next = 1'b1;
            fidx_next = cmp_idx_reg;
        end
        if (ctl.scan_clear)
            have_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= ctl.scan_issue;
            have_reg      <= have_next;
            if (ctl.result_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg   <= command;
            key_reg  <= key;
            slot_reg <= slot;
        end
        if (ctl.scan_issue)
            cmp_idx_reg <= idx_reg[ADDR_W-1:0];
        if (ctl.ref_load)
            ref_reg <= rd_data_reg;
        best_reg <= best_next;
        fidx_reg <= fidx_next;
        if (ctl.stat_load)
            stat_reg <= ctl.stat_code;
        if (ctl.result_load)
        begin
            status_reg      <= stat_reg;
            entry_count_reg <= fill_reg;
            found_index_reg <= (stat_reg == ST_OK && op_reg == CMD_SEARCH) ?
                               fidx_reg : '0;
            found_value_reg <= (stat_reg == ST_OK && (op_reg == CMD_MIN ||
                               op_reg == CMD_MAX || op_reg == CMD_PRED ||
                               op_reg == CMD_SUCC)) ? best_reg : '0;
        end
    end

    assign stat.op          = op_reg;
    assign stat.full        = (fill_reg == CNT_W'(CAPACITY));
    assign stat.empty       = (fill_reg == '0);
    assign stat.slot_bad    = ({1'b0, slot_reg} >= fill_reg);
    assign stat.issue_done  = (idx_reg >= fill_reg);
    assign stat.cmp_pending = cmp_valid_reg;
    assign stat.have        = have_reg;
    assign stat.out_busy    = out_valid_reg & ~out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = found_index_reg;
    assign found_value = found_value_reg;
    assign entry_count = entry_count_reg;

endmodule
`default_nettype wire

/* rtl/ukt_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_ctrl
// Command sequencer: decode, delete move, reference fetch, scan, hand-off.
// ----------------------------------------------------------------------------
module ukt_ctrl
    import ukt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ukt_stat_t stat,
    output ukt_cmd_t       ctl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_DEL_WR = 3'd2;
    localparam logic [2:0] S_REF    = 3'd3;
    localparam logic [2:0] S_SCAN   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctl.capture = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                ctl.stat_load = 1'b1;
                ctl.stat_code = ST_OK;
                state_next    = S_FINISH;
                case (stat.op)
                    CMD_INSERT:
                    begin
                        if (stat.full)
                            ctl.stat_code = ST_FULL;
                        else
                            ctl.ins_write = 1'b1;
                    end
                    CMD_DELETE:
                    begin
                        if (stat.slot_bad)
                            ctl.stat_code = ST_BAD;
                        else
                        begin
                            ctl.rd_last = 1'b1;
                            state_next  = S_DEL_WR;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        ctl.scan_clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                    CMD_MIN, CMD_MAX:
                    begin
                        if (stat.empty)
                            ctl.stat_code = ST_BAD;
                        else
                        begin
                            ctl.scan_clear = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    CMD_PRED, CMD_SUCC:
                    begin
                        if (stat.slot_bad)
                            ctl.stat_code = ST_BAD;
                        else
                        begin
                            ctl.rd_slot = 1'b1;
                            state_next  = S_REF;
                        end
                    end
                    default: ctl.stat_code = ST_BAD;
                endcase
            end
            S_DEL_WR:
            begin
                ctl.del_write = 1'b1;
                state_next    = S_FINISH;
            end
            S_REF:
            begin
                ctl.ref_load   = 1'b1;
                ctl.scan_clear = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                if (!stat.issue_done)
                    ctl.scan_issue = 1'b1;
                else if (!stat.cmp_pending)
                begin
                    ctl.stat_load = 1'b1;
                    ctl.stat_code = stat.have ? ST_OK : ST_NOT_FOUND;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    ctl.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* rtl/unsorted_key_table_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Insert and rejected commands go from decode to the hand-off; delete
//   first moves the last entry into the freed slot; search, min and max
//   scan the table and pred/succ first fetch the reference key, one read
//   per entry. One command at a time; the single read port of the key
//   memory sets the scan length.
// Reset: asynchronous, active low; empties the table and drops any result.
// ----------------------------------------------------------------------------
// unsorted_key_table_unit
// Table of signed 32-bit keys in arrival order with insert, swap-with-last
// delete, first-match search, min, max, predecessor and successor.
// ----------------------------------------------------------------------------
module unsorted_key_table_unit
    import ukt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // input words
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [2:0]              command,
    input  wire logic signed [KEY_W-1:0] key,
    input  wire logic [ADDR_W-1:0]       slot,
    // result words
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   status,
    output logic [ADDR_W-1:0]            found_index,
    output logic signed [KEY_W-1:0]      found_value,
    output logic [CNT_W-1:0]             entry_count
);

    // Controller walks each command through decode, an optional memory
    // fetch (last entry for delete, reference key for pred/succ), a scan of
    // every stored entry for lookups and the hand-off into the output register.
    // The output register lets the next word be taken while a result waits.
    ukt_cmd_t  ctl;
    ukt_stat_t stat;

    ukt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Datapath: 256 x 32 memory with registered read, fill count, scan
    // address and compare pipeline, result register.
    ukt_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .key         (key),
        .slot        (slot),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .found_index (found_index),
        .found_value (found_value),
        .entry_count (entry_count)
    );

endmodule
`default_nettype wire

/* rtl/ukt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ukt_checker
// Port-level checks on the unsorted key table, bound to the top level.
// ----------------------------------------------------------------------------
module ukt_checker
    import ukt_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [1:0]              status,
    input wire logic [ADDR_W-1:0]       found_index,
    input wire logic signed [KEY_W-1:0] found_value,
    input wire logic [CNT_W-1:0]        entry_count
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(found_index) && $stable(found_value) && $stable(entry_count))
        else $error("result word changed while stalled");

    // one command in flight: no back-to-back accept
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word taken while busy");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> found_index == '0 && found_value == '0)
        else $error("non-zero payload on failed command");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> entry_count == CNT_W'(CAPACITY))
        else $error("full reported with room left");

endmodule

bind unsorted_key_table_unit ukt_checker u_ukt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .found_index (found_index),
    .found_value (found_value),
    .entry_count (entry_count)
);
`default_nettype wire
